// ----- rtl/core/multiplexed_seven_segment_driver_core_defines.svh -----
// Assertion macros shared by the checker of the seven-segment driver core.
// Needs signals named clk and arst_n in the scope where a macro is used.
`ifndef MULTIPLEXED_SEVEN_SEGMENT_DRIVER_CORE_DEFINES_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_DRIVER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define MSSD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define MSSD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/mssd_pkg.sv -----
// Shared types, constants and segment functions of the seven-segment driver core.
// No dependencies.
package mssd_pkg;

	localparam int ENTRIES     = 4;
	localparam int ENTRY_W     = 2;
	localparam int ADDR_W      = 3;
	localparam int NUMBER_W    = 16;
	localparam int S_DATA_W    = 24;
	localparam int TABLE_BITS  = 7;
	localparam int SEG_MAP_W   = 21;
	localparam int DIG_MAP_W   = 8;
	localparam int COUNT_W     = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 21;
	localparam int PROD_W      = 32;
	localparam int DIV10_SHIFT = 19;

	localparam logic [NUMBER_W-1:0]  DIV10_MUL     = 16'hCCCD;
	localparam logic [SEG_MAP_W-1:0] SEG_MAP_RST   = 21'd1762760;
	localparam logic [DIG_MAP_W-1:0] DIG_MAP_RST   = 8'd228;
	localparam logic [COUNT_W-1:0]   COUNT_RST     = 3'd4;
	localparam logic [COUNT_W-1:0]   COUNT_MAX     = 3'd4;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEG_MAP    = 2'd0,
		CFG_DIG_MAP    = 2'd1,
		CFG_SCAN_COUNT = 2'd2
	} cfg_idx_t;

	// Buffer memory access request
	typedef struct packed {
		logic              rd;
		logic              wr;
		logic [ADDR_W-1:0] addr;
	} mem_req_t;

	// Scan word hand-off to the output register
	typedef struct packed {
		logic valid;
		logic last;
	} emit_t;

	// Decimal digit to segment pattern, bit 6 = segment a
	function automatic logic [TABLE_BITS-1:0] seg_pattern(input logic [3:0] digit);
		logic [TABLE_BITS-1:0] pat;
		case (digit)
			4'd0:    pat = 7'b1111110;
			4'd1:    pat = 7'b0110000;
			4'd2:    pat = 7'b1101101;
			4'd3:    pat = 7'b1111001;
			4'd4:    pat = 7'b0110011;
			4'd5:    pat = 7'b1011011;
			4'd6:    pat = 7'b1011111;
			4'd7:    pat = 7'b1110000;
			4'd8:    pat = 7'b1111111;
			4'd9:    pat = 7'b1111011;
			default: pat = '0;
		endcase
		return pat;
	endfunction

	// Move each pattern bit to its configured 3-bit pin position
	function automatic logic [7:0] seg_remap(input logic [TABLE_BITS-1:0] pat,
			input logic [SEG_MAP_W-1:0] map);
		logic [7:0] res;
		res = '0;
		for (int b = 0; b < TABLE_BITS; b++) begin
			if (pat[b]) begin
				res[map[3*b +: 3]] = 1'b1;
			end
		end
		return res;
	endfunction

endpackage

// ----- rtl/core/mssd_bufmem.sv -----
// Front/back display buffer memory: two banks, synchronous read.
// Depends on mssd_pkg. Per-entry valid bits give the reset contents.
module mssd_bufmem import mssd_pkg::*; #(
	parameter int WORD_BITS = 11,
	parameter int SEGMENTS  = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mem_req_t             req,
	input  logic [WORD_BITS-1:0] wdata,
	output logic [WORD_BITS-1:0] rdata
);

	localparam int DEPTH = 2 * ENTRIES;

	logic [WORD_BITS-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]     valid_q;
	logic [WORD_BITS-1:0] rdata_s1;
	logic                 vld_s1;
	logic [ENTRY_W-1:0]   ent_s1;
	logic [WORD_BITS-1:0] init_word;

	// Storage array
	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem_q[req.addr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (req.rd) begin
			rdata_s1 <= mem_q[req.addr];
			ent_s1   <= req.addr[ENTRY_W-1:0];
		end
	end

	// Written-entry flags, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (req.wr) begin
				valid_q[req.addr] <= 1'b1;
			end
			if (req.rd) begin
				vld_s1 <= valid_q[req.addr];
			end
		end
	end

	// Reset contents: entry i carries only its digit-select bit
	always_comb begin
		init_word = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (SEGMENTS + i < WORD_BITS && ent_s1 == ENTRY_W'(i)) begin
				init_word[SEGMENTS+i] = 1'b1;
			end
		end
	end

	assign rdata = vld_s1 ? rdata_s1 : init_word;

endmodule

// ----- rtl/core/mssd_ctrl.sv -----
// Sequencer of the seven-segment driver: decimal split, back-buffer updates, scan-out.
// Depends on mssd_pkg; drives the buffer memory in mssd_bufmem.
module mssd_ctrl import mssd_pkg::*; #(
	parameter int DIGITS    = 4,
	parameter int SEGMENTS  = 7,
	parameter int WORD_BITS = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_func,
	input  logic [NUMBER_W-1:0]   in_number,
	input  logic                  in_lz,
	input  logic [SEG_MAP_W-1:0]  seg_map,
	input  logic [DIG_MAP_W-1:0]  dig_map,
	input  logic [COUNT_W-1:0]    scan_count,
	output mem_req_t              mem_req,
	output logic [WORD_BITS-1:0]  mem_wdata,
	input  logic [WORD_BITS-1:0]  mem_rdata,
	input  logic                  out_free,
	output emit_t                 emit,
	output logic [WORD_BITS-1:0]  emit_word
);

	localparam int NDIG = (DIGITS < ENTRIES) ? DIGITS : ENTRIES;
	localparam logic [ENTRY_W-1:0]   LAST_DIGIT = ENTRY_W'(NDIG - 1);
	localparam logic [WORD_BITS-1:0] KEEP = {{DIGITS{1'b1}}, {SEGMENTS{1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DRD  = 4'b0010,
		ST_DWR  = 4'b0100,
		ST_SCAN = 4'b1000
	} state_t;

	state_t               state_q;
	logic [NUMBER_W-1:0]  value_q;
	logic                 lz_q;
	logic [ENTRY_W-1:0]   digit_q;
	logic                 sel_q;
	logic                 pending_q;
	logic [ENTRY_W-1:0]   pos_q;
	logic [3:0]           rem_s1;
	logic                 show_s1;
	logic [ENTRY_W-1:0]   entry_s1;

	logic                 accept;
	logic [ENTRY_W-1:0]   entry_sel;
	logic [PROD_W-1:0]    prod;
	logic [NUMBER_W-1:0]  quot;
	logic [NUMBER_W-1:0]  tenfold;
	logic [NUMBER_W-1:0]  rem_full;
	logic [COUNT_W-1:0]   count_c;
	logic [ENTRY_W-1:0]   last_pos;
	logic                 scan_end;
	logic                 out_fire;
	logic [7:0]           seg8;
	logic [WORD_BITS-1:0] placed;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Buffer entry for the current digit
	assign entry_sel = dig_map[digit_q*ENTRY_W +: ENTRY_W];

	// Divide by ten through the reciprocal, exact for 16-bit values
	assign prod     = PROD_W'(value_q) * PROD_W'(DIV10_MUL);
	assign quot     = NUMBER_W'(prod[PROD_W-1:DIV10_SHIFT]);
	assign tenfold  = NUMBER_W'({quot, 3'b000}) + NUMBER_W'({quot, 1'b0});
	assign rem_full = value_q - tenfold;

	// Scan length clamped to 1..4
	always_comb begin
		count_c = scan_count;
		if (scan_count == '0) begin
			count_c = COUNT_W'(1);
		end else if (scan_count > COUNT_MAX) begin
			count_c = COUNT_MAX;
		end
	end
	assign last_pos = ENTRY_W'(count_c - COUNT_W'(1));
	assign scan_end = (pos_q >= last_pos);
	assign out_fire = (state_q == ST_SCAN) && out_free;

	// New segment bits for the entry being rewritten
	assign seg8 = seg_remap(seg_pattern(rem_s1), seg_map);
	always_comb begin
		placed = '0;
		for (int p = 0; p < 8; p++) begin
			if (p < WORD_BITS) begin
				placed[p] = seg8[p];
			end
		end
	end
	assign mem_wdata = (mem_rdata & KEEP) | (show_s1 ? placed : '0);

	// Memory requests: front bank for scan, back bank for updates
	always_comb begin
		mem_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_func) begin
					mem_req.rd   = 1'b1;
					mem_req.addr = {sel_q, pos_q};
				end
			end
			ST_DRD: begin
				mem_req.rd   = 1'b1;
				mem_req.addr = {~sel_q, entry_sel};
			end
			ST_DWR: begin
				mem_req.wr   = 1'b1;
				mem_req.addr = {~sel_q, entry_s1};
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	assign emit.valid = out_fire;
	assign emit.last  = scan_end;
	assign emit_word  = mem_rdata;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			digit_q   <= '0;
			sel_q     <= 1'b0;
			pending_q <= 1'b0;
			pos_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_func) begin
							state_q <= ST_SCAN;
						end else begin
							digit_q <= '0;
							state_q <= ST_DRD;
						end
					end
				end
				ST_DRD: begin
					state_q <= ST_DWR;
				end
				ST_DWR: begin
					digit_q <= digit_q + ENTRY_W'(1);
					if (digit_q == LAST_DIGIT) begin
						pending_q <= 1'b1;
						state_q   <= ST_IDLE;
					end else begin
						state_q <= ST_DRD;
					end
				end
				ST_SCAN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (scan_end) begin
							pos_q <= '0;
							if (pending_q) begin
								sel_q     <= ~sel_q;
								pending_q <= 1'b0;
							end
						end else begin
							pos_q <= pos_q + ENTRY_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Digit datapath
	always_ff @(posedge clk) begin
		if (accept && !in_func) begin
			value_q <= in_number;
			lz_q    <= in_lz;
		end else if (state_q == ST_DRD) begin
			value_q  <= quot;
			rem_s1   <= rem_full[3:0];
			show_s1  <= (value_q != '0) || (digit_q == '0) || lz_q;
			entry_s1 <= entry_sel;
		end
	end

endmodule

// ----- rtl/core/multiplexed_seven_segment_driver_core.sv -----
// Show number: no result; next request accepted once all min(DIGITS,4) digits are written.
// Scan tick: memory read, scan state, output register; next request taken after the scan state.
// Each digit is a read-modify-write on the single buffer memory port: a read state, then a write.
// A full, stalled output register holds the scan tick and with it the input.
// Async active-low reset: registers to defaults, buffers read as select bits only,
// front bank 0, no swap pending, scan position 0.
module multiplexed_seven_segment_driver_core import mssd_pkg::*; #(
	parameter int DIGITS   = 4,
	parameter int SEGMENTS = 7,
	localparam int WORD_BITS = SEGMENTS + DIGITS,
	localparam int M_DATA_W  = ((WORD_BITS + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [S_DATA_W-1:0]    s_tdata,   // [15:0] number, [16] leading_zeros
	input  logic                   s_tuser,   // [0] func
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [M_DATA_W-1:0]    m_tdata,   // [WORD_BITS-1:0] pin_word
	output logic                   m_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [SEG_MAP_W-1:0] seg_map_q;
	logic [DIG_MAP_W-1:0] dig_map_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 m_tvalid_q;
	logic [WORD_BITS-1:0] pin_q;
	logic                 last_q;

	mem_req_t             mem_req;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [WORD_BITS-1:0] mem_rdata;
	emit_t                emit;
	logic [WORD_BITS-1:0] emit_word;
	logic                 out_free;

	// Configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_map_q <= SEG_MAP_RST;
			dig_map_q <= DIG_MAP_RST;
			count_q   <= COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SEG_MAP:    seg_map_q <= cfg_data[SEG_MAP_W-1:0];
				CFG_DIG_MAP:    dig_map_q <= cfg_data[DIG_MAP_W-1:0];
				CFG_SCAN_COUNT: count_q   <= cfg_data[COUNT_W-1:0];
				default: begin
					seg_map_q <= seg_map_q;
				end
			endcase
		end
	end

	mssd_bufmem #(
		.WORD_BITS(WORD_BITS),
		.SEGMENTS (SEGMENTS)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mem_req),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	mssd_ctrl #(
		.DIGITS   (DIGITS),
		.SEGMENTS (SEGMENTS),
		.WORD_BITS(WORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_func   (s_tuser),
		.in_number (s_tdata[NUMBER_W-1:0]),
		.in_lz     (s_tdata[NUMBER_W]),
		.seg_map   (seg_map_q),
		.dig_map   (dig_map_q),
		.scan_count(count_q),
		.mem_req   (mem_req),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata),
		.out_free  (out_free),
		.emit      (emit),
		.emit_word (emit_word)
	);

	// Output register
	assign out_free = !m_tvalid_q || m_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			pin_q  <= emit_word;
			last_q <= emit.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_W'(pin_q);
	assign m_tlast  = last_q;

endmodule

// ----- rtl/core/mssd_checker.sv -----
// Port-level checks of the seven-segment driver core, bound to the top level.
// Depends on mssd_pkg and the assertion macro header.
`include "multiplexed_seven_segment_driver_core_defines.svh"

module mssd_checker import mssd_pkg::*; #(
	parameter int M_DATA_W = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                s_tuser,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tlast
);

	// A stalled result holds
	`MSSD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

	// The block is busy right after taking a request
	`MSSD_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "request taken while busy")

	// A show-number request never produces a result
	`MSSD_ASSERT_NXT(a_show_silent, s_tvalid && s_tready && !s_tuser && !m_tvalid, !m_tvalid, "result from show-number request")

	// A scan tick with a free output shows its word once the scan state has loaded the output register
	`MSSD_ASSERT_NXT(a_scan_latency, s_tvalid && s_tready && s_tuser && !m_tvalid, !m_tvalid ##1 m_tvalid, "scan word latency")

endmodule

bind multiplexed_seven_segment_driver_core mssd_checker #(
	.M_DATA_W(M_DATA_W)
) u_mssd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
